// File: hw/rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants and sequencer states of the triangle tangent basis core.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

  localparam int unsigned TTB_COORD_WIDTH = 32;
  localparam int unsigned TTB_FRAC_BITS   = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DETCHK,
    ST_DLOAD,
    ST_DIV,
    ST_DSTORE,
    ST_DONE
  } ttb_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/ttb_if.sv
// ----------------------------------------------------------------------------
// ttb_vtx_if / ttb_res_if
// Valid/ready channels for vertex items and tangent basis result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttb_vtx_if import ttb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = TTB_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] tex_u;
  logic signed [COORD_WIDTH-1:0] tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_res_if import ttb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = TTB_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] tangent_x;
  logic signed [COORD_WIDTH-1:0] tangent_y;
  logic signed [COORD_WIDTH-1:0] tangent_z;
  logic signed [COORD_WIDTH-1:0] bitangent_x;
  logic signed [COORD_WIDTH-1:0] bitangent_y;
  logic signed [COORD_WIDTH-1:0] bitangent_z;
  logic                          degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/triangle_tangent_basis_core.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_core
// Per-triangle tangent and bitangent from three vertices, bit-serial
// shift-add multiplier and restoring divider.
// ----------------------------------------------------------------------------
//  channel | dir | item                                   | handshake
//  vtx_i   | in  | pos_x/y/z, tex_u/v                     | valid/ready
//  res_o   | out | tangent_x/y/z, bitangent_x/y/z, degen. | valid/ready
//
//  First two vertices of a triangle: stored while idle, no result.
//  Third vertex: with D = COORD_WIDTH+1, A = 2*D+1, the determinant and six
//  quotients are computed on D-bit differences and an A-bit accumulator by
//  the one-bit-per-cycle multiplier and divider; degenerate ones skip division.
//  Reset clears the vertex phase and the handshake; held vertices are
//  undefined until written. A stalled result holds off the third vertex of
//  the next triangle until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_basis_core import ttb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = TTB_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = TTB_FRAC_BITS
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  ttb_vtx_if.sink   vtx_i,
  ttb_res_if.source res_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned AW   = 2 * DW + 1;
  localparam int unsigned NSTP = AW + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(NSTP + 1);

  ttb_state_e state_q, state_d;

  logic [1:0]      phase_q;
  logic [CW-1:0]   hp_q [6];
  logic [CW-1:0]   ht_q [4];
  logic [DW-1:0]   dp1_q [3];
  logic [DW-1:0]   dp2_q [3];
  logic [DW-1:0]   du1_q, dv1_q, du2_q, dv2_q;
  logic [2:0]      op_q;
  logic            term_q;
  logic [CNTW-1:0] cnt_q;
  logic [AW-1:0]   acc_q, mcand_q, den_q, num_q, rem_q;
  logic [DW-1:0]   mplier_q;
  logic            mneg_q, dneg_q, qneg_q, ovf_q, deg_q;
  logic [CW-1:0]   quo_q;
  logic [CW-1:0]   res_q [6];
  logic            ov_q;

  logic          in_acc, out_free, mul_last, div_last, acc_zero;
  logic [1:0]    sel_k;
  logic [DW-1:0] a0, b0, a1, b1, opa, opb, mag_a, mag_b;
  logic [AW-1:0] acc_mag;
  logic [AW:0]   rem2, den_x;
  logic          ge;
  logic [CW-1:0] limit, qm, qres;
  logic          big;

  assign in_acc   = vtx_i.valid & vtx_i.ready;
  assign out_free = ~ov_q | res_o.ready;
  assign mul_last = cnt_q == CNTW'(DW - 1);
  assign div_last = cnt_q == CNTW'(NSTP - 1);
  assign acc_zero = acc_q == '0;
  assign acc_mag  = acc_q[AW-1] ? -acc_q : acc_q;

  // operand pairs: term 0 adds a0*b0, term 1 subtracts a1*b1
  assign sel_k = (op_q >= 3'd4) ? 2'(op_q - 3'd4) : 2'(op_q - 3'd1);
  always_comb begin
    if (op_q == 3'd0) begin
      a0 = du1_q; b0 = dv2_q; a1 = dv1_q; b1 = du2_q;
    end else if (op_q < 3'd4) begin
      a0 = dp1_q[sel_k]; b0 = dv2_q; a1 = dp2_q[sel_k]; b1 = dv1_q;
    end else begin
      a0 = dp2_q[sel_k]; b0 = du1_q; a1 = dp1_q[sel_k]; b1 = du2_q;
    end
  end
  assign opa   = term_q ? a1 : a0;
  assign opb   = term_q ? b1 : b0;
  assign mag_a = opa[DW-1] ? -opa : opa;
  assign mag_b = opb[DW-1] ? -opb : opb;

  assign rem2  = {rem_q, num_q[AW-1]};
  assign den_x = {1'b0, den_q};
  assign ge    = rem2 >= den_x;

  assign limit = qneg_q ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  assign big   = ovf_q | (quo_q[CW-1] & (~qneg_q | (|quo_q[CW-2:0])));
  assign qm    = big ? limit : quo_q;
  assign qres  = qneg_q ? -qm : qm;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && phase_q == 2'd2) state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_MUL;
      ST_MUL: begin
        if (mul_last) begin
          if (!term_q)           state_d = ST_LOAD;
          else if (op_q == 3'd0) state_d = ST_DETCHK;
          else                   state_d = ST_DLOAD;
        end
      end
      ST_DETCHK: state_d = acc_zero ? ST_DONE : ST_LOAD;
      ST_DLOAD:  state_d = ST_DIV;
      ST_DIV:    if (div_last) state_d = ST_DSTORE;
      ST_DSTORE: state_d = (op_q == 3'd6) ? ST_DONE : ST_LOAD;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    vtx_i.ready       = (state_q == ST_IDLE) && !(ov_q && phase_q == 2'd2);
    res_o.valid       = ov_q;
    res_o.tangent_x   = res_q[0];
    res_o.tangent_y   = res_q[1];
    res_o.tangent_z   = res_q[2];
    res_o.bitangent_x = res_q[3];
    res_o.bitangent_y = res_q[4];
    res_o.bitangent_z = res_q[5];
    res_o.degenerate  = deg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 2'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) phase_q <= (phase_q == 2'd1) ? 2'd2 : (phase_q == 2'd2) ? 2'd0 : 2'd1;
      if (state_q == ST_DONE && out_free) ov_q <= 1'b1;
      else if (res_o.ready)               ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (phase_q == 2'd1) begin
            hp_q[3] <= vtx_i.pos_x; hp_q[4] <= vtx_i.pos_y; hp_q[5] <= vtx_i.pos_z;
            ht_q[2] <= vtx_i.tex_u; ht_q[3] <= vtx_i.tex_v;
          end else if (phase_q == 2'd2) begin
            for (int k = 0; k < 3; k++) begin
              dp1_q[k] <= {hp_q[3+k][CW-1], hp_q[3+k]} - {hp_q[k][CW-1], hp_q[k]};
            end
            dp2_q[0] <= {vtx_i.pos_x[CW-1], vtx_i.pos_x} - {hp_q[0][CW-1], hp_q[0]};
            dp2_q[1] <= {vtx_i.pos_y[CW-1], vtx_i.pos_y} - {hp_q[1][CW-1], hp_q[1]};
            dp2_q[2] <= {vtx_i.pos_z[CW-1], vtx_i.pos_z} - {hp_q[2][CW-1], hp_q[2]};
            du1_q    <= {ht_q[2][CW-1], ht_q[2]} - {ht_q[0][CW-1], ht_q[0]};
            dv1_q    <= {ht_q[3][CW-1], ht_q[3]} - {ht_q[1][CW-1], ht_q[1]};
            du2_q    <= {vtx_i.tex_u[CW-1], vtx_i.tex_u} - {ht_q[0][CW-1], ht_q[0]};
            dv2_q    <= {vtx_i.tex_v[CW-1], vtx_i.tex_v} - {ht_q[1][CW-1], ht_q[1]};
            op_q     <= 3'd0;
            term_q   <= 1'b0;
            acc_q    <= '0;
            deg_q    <= 1'b0;
          end else begin
            hp_q[0] <= vtx_i.pos_x; hp_q[1] <= vtx_i.pos_y; hp_q[2] <= vtx_i.pos_z;
            ht_q[0] <= vtx_i.tex_u; ht_q[1] <= vtx_i.tex_v;
          end
        end
      end
      ST_LOAD: begin
        mcand_q  <= AW'(mag_a);
        mplier_q <= mag_b;
        mneg_q   <= opa[DW-1] ^ opb[DW-1] ^ term_q;
        cnt_q    <= '0;
      end
      ST_MUL: begin
        if (mplier_q[0]) acc_q <= mneg_q ? acc_q - mcand_q : acc_q + mcand_q;
        mcand_q  <= {mcand_q[AW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[DW-1:1]};
        cnt_q    <= cnt_q + 1'b1;
        if (mul_last && !term_q) term_q <= 1'b1;
      end
      ST_DETCHK: begin
        if (acc_zero) begin
          deg_q <= 1'b1;
          for (int k = 0; k < 6; k++) res_q[k] <= '0;
        end
        den_q  <= acc_mag;
        dneg_q <= acc_q[AW-1];
        op_q   <= 3'd1;
        term_q <= 1'b0;
        acc_q  <= '0;
      end
      ST_DLOAD: begin
        num_q  <= acc_mag;
        qneg_q <= acc_q[AW-1] ^ dneg_q;
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        cnt_q  <= '0;
      end
      ST_DIV: begin
        rem_q <= ge ? AW'(rem2 - den_x) : AW'(rem2);
        num_q <= {num_q[AW-2:0], 1'b0};
        quo_q <= {quo_q[CW-2:0], ge};
        ovf_q <= ovf_q | quo_q[CW-1];
        cnt_q <= cnt_q + 1'b1;
      end
      ST_DSTORE: begin
        res_q[3'(op_q - 3'd1)] <= qres;
        op_q   <= op_q + 3'd1;
        term_q <= 1'b0;
        acc_q  <= '0;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker
// Port-level checks of the triangle tangent basis core, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_checker import ttb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = TTB_COORD_WIDTH
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_ready_i,
  input wire                   out_valid_i,
  input wire                   out_ready_i,
  input wire [COORD_WIDTH-1:0] tx_i,
  input wire [COORD_WIDTH-1:0] ty_i,
  input wire [COORD_WIDTH-1:0] tz_i,
  input wire [COORD_WIDTH-1:0] bx_i,
  input wire [COORD_WIDTH-1:0] by_i,
  input wire [COORD_WIDTH-1:0] bz_i,
  input wire                   deg_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_i) && $stable(deg_i))
    else $error("result item changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && deg_i |-> tx_i == '0 && ty_i == '0 && tz_i == '0 &&
                             bx_i == '0 && by_i == '0 && bz_i == '0)
    else $error("degenerate item carries non-zero vectors");

  a_new_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result item appeared without a computation");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !$rose(out_valid_i))
    else $error("result item appeared right after a vertex");

endmodule

bind triangle_tangent_basis_core ttb_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ttb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vtx_i.valid),
  .in_ready_i  (vtx_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .tx_i        (res_o.tangent_x),
  .ty_i        (res_o.tangent_y),
  .tz_i        (res_o.tangent_z),
  .bx_i        (res_o.bitangent_x),
  .by_i        (res_o.bitangent_y),
  .bz_i        (res_o.bitangent_z),
  .deg_i       (res_o.degenerate)
);

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for triangle_tangent_basis_core. It sends vertex items over the
// vertex channel and predicts each triangle's tangent, bitangent and
// degenerate flag. Each result item is checked field by field against the
// oldest predicted result. The items are directed corner triangles, then
// random triangles under three patterns of idling on the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttb_pkg::*;

  localparam int unsigned CW        = TTB_COORD_WIDTH;
  localparam int unsigned FB        = TTB_FRAC_BITS;
  localparam int unsigned MAX_CYC   = 3_000_000;
  localparam int unsigned DRAIN_CYC = 1_200;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;

  typedef struct packed {
    coord_t px, py, pz, tu, tv;
  } vertex_t;

  typedef struct packed {
    coord_t tx, ty, tz, bx, by, bz;
    logic   degen;
  } basis_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ttb_vtx_if #(.COORD_WIDTH(CW)) vtx ();
  ttb_res_if #(.COORD_WIDTH(CW)) res ();

  triangle_tangent_basis_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx.sink),
    .res_o (res.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  basis_t  basis_q[$];
  vertex_t held_v0, held_v1;
  int      tri_phase = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      n_errors = 0;
  int      n_vertices = 0;
  int      n_results = 0;
  int      n_degen = 0;
  int      n_sat = 0;
  int      cycles = 0;

  initial begin
    vtx.valid = 1'b0;
    vtx.pos_x = '0;
    vtx.pos_y = '0;
    vtx.pos_z = '0;
    vtx.tex_u = '0;
    vtx.tex_v = '0;
    res.ready = 1'b0;
  end

  function automatic coord_t sat_quot(wide_t num, wide_t det);
    wide_t q;
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = (wide_t'(1) <<< (CW - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (CW - 1));
    q = (num <<< FB) / det;
    if (q > hi_lim) return coord_t'(hi_lim);
    if (q < lo_lim) return coord_t'(lo_lim);
    return coord_t'(q);
  endfunction

  // tangent = (dP1*dv2 - dP2*dv1)/det, bitangent = (dP2*du1 - dP1*du2)/det
  function automatic basis_t tangent_basis(vertex_t a, vertex_t b, vertex_t c);
    wide_t  dp1[3];
    wide_t  dp2[3];
    wide_t  du1, dv1, du2, dv2, det;
    wide_t  pa[3];
    wide_t  pb[3];
    wide_t  pc[3];
    coord_t t[3];
    coord_t bt[3];
    basis_t r;
    pa[0] = wide_t'(a.px); pa[1] = wide_t'(a.py); pa[2] = wide_t'(a.pz);
    pb[0] = wide_t'(b.px); pb[1] = wide_t'(b.py); pb[2] = wide_t'(b.pz);
    pc[0] = wide_t'(c.px); pc[1] = wide_t'(c.py); pc[2] = wide_t'(c.pz);
    for (int k = 0; k < 3; k++) begin
      dp1[k] = pb[k] - pa[k];
      dp2[k] = pc[k] - pa[k];
    end
    du1 = wide_t'(b.tu) - wide_t'(a.tu);
    dv1 = wide_t'(b.tv) - wide_t'(a.tv);
    du2 = wide_t'(c.tu) - wide_t'(a.tu);
    dv2 = wide_t'(c.tv) - wide_t'(a.tv);
    det = du1 * dv2 - dv1 * du2;
    r = '0;
    if (det == 0) begin
      r.degen = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      t[k]  = sat_quot(dp1[k] * dv2 - dp2[k] * dv1, det);
      bt[k] = sat_quot(dp2[k] * du1 - dp1[k] * du2, det);
    end
    r.tx = t[0];  r.ty = t[1];  r.tz = t[2];
    r.bx = bt[0]; r.by = bt[1]; r.bz = bt[2];
    return r;
  endfunction

  function automatic bit is_sat(coord_t x);
    return x == {1'b0, {(CW-1){1'b1}}} || x == {1'b1, {(CW-1){1'b0}}};
  endfunction

  function automatic void accept_vertex(vertex_t v);
    basis_t e;
    n_vertices++;
    case (tri_phase)
      0: begin
        held_v0 = v;
        tri_phase = 1;
      end
      1: begin
        held_v1 = v;
        tri_phase = 2;
      end
      default: begin
        e = tangent_basis(held_v0, held_v1, v);
        if (e.degen) n_degen++;
        if (is_sat(e.tx) || is_sat(e.ty) || is_sat(e.tz) ||
            is_sat(e.bx) || is_sat(e.by) || is_sat(e.bz)) n_sat++;
        basis_q.push_back(e);
        tri_phase = 0;
      end
    endcase
  endfunction

  // valid is left high after acceptance; the next call either keeps it or idles
  task automatic send_vertex(vertex_t v);
    if ($urandom_range(99) < send_idle_pct) begin
      vtx.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    vtx.valid <= 1'b1;
    vtx.pos_x <= v.px;
    vtx.pos_y <= v.py;
    vtx.pos_z <= v.pz;
    vtx.tex_u <= v.tu;
    vtx.tex_v <= v.tv;
    do @(posedge clk_i); while (!(vtx.valid && vtx.ready));
    accept_vertex(v);
  endtask

  task automatic send_triangle(vertex_t a, vertex_t b, vertex_t c);
    send_vertex(a);
    send_vertex(b);
    send_vertex(c);
  endtask

  function automatic vertex_t mk_vtx(coord_t px, coord_t py, coord_t pz,
                                     coord_t tu, coord_t tv);
    vertex_t v;
    v.px = px; v.py = py; v.pz = pz; v.tu = tu; v.tv = tv;
    return v;
  endfunction

  function automatic coord_t rnd_coord();
    case ($urandom_range(3))
      0:       return coord_t'($urandom);
      1:       return coord_t'($signed($urandom_range(8 << FB)) - (4 << FB));
      2:       return coord_t'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    endcase
  endfunction

  function automatic vertex_t rnd_vtx();
    return mk_vtx(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
  endfunction

  task automatic wait_drained();
    vtx.valid <= 1'b0;
    while (basis_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    coord_t one;
    coord_t mx;
    coord_t mn;
    one = coord_t'(1 << FB);
    mx  = {1'b0, {(CW-1){1'b1}}};
    mn  = {1'b1, {(CW-1){1'b0}}};
    // unit right triangle
    send_triangle(mk_vtx(0, 0, 0, 0, 0), mk_vtx(one, 0, 0, one, 0),
                  mk_vtx(0, one, 0, 0, one));
    // degenerate: all texture coordinates equal
    send_triangle(mk_vtx(one, 2, 3, 5, 5), mk_vtx(7, one, 9, 5, 5),
                  mk_vtx(4, 4, one, 5, 5));
    // degenerate: collinear texture coordinates
    send_triangle(mk_vtx(0, 0, 0, 0, 0), mk_vtx(one, one, one, 1, 1),
                  mk_vtx(-one, one, 0, 2, 2));
    // smallest determinant with big edges: saturates both ways
    send_triangle(mk_vtx(mn, mx, mn, 0, 0), mk_vtx(mx, mn, mx, 1, 0),
                  mk_vtx(mn, mx, mx, 0, 1));
    // field extremes everywhere
    send_triangle(mk_vtx(mx, mx, mx, mx, mx), mk_vtx(mn, mn, mn, mn, mx),
                  mk_vtx(mx, mn, mx, mn, mn));
    send_triangle(mk_vtx(mn, mn, mn, mn, mn), mk_vtx(mx, mx, mx, mx, mn),
                  mk_vtx(-1, 0, 1, mn, mx));
    // negative determinant, small values
    send_triangle(mk_vtx(3, -5, 7, 0, 0), mk_vtx(-9, 11, -13, 0, one),
                  mk_vtx(17, -19, 23, one, 0));
  endtask

  task automatic test_random(int n_tri);
    vertex_t a, b, c;
    for (int i = 0; i < n_tri; i++) begin
      a = rnd_vtx();
      b = rnd_vtx();
      c = rnd_vtx();
      if ($urandom_range(9) == 0) begin
        c.tu = a.tu;
        c.tv = a.tv;
      end
      send_triangle(a, b, c);
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  task automatic test_pause();
    wait_drained();
    test_random(3);
  endtask

  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    basis_t e;
    if (rst_ni && res.valid && res.ready) begin
      n_results++;
      if (basis_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: result item with none expected");
      end else begin
        e = basis_q.pop_front();
        if (res.tangent_x !== e.tx || res.tangent_y !== e.ty ||
            res.tangent_z !== e.tz || res.bitangent_x !== e.bx ||
            res.bitangent_y !== e.by || res.bitangent_z !== e.bz ||
            res.degenerate !== e.degen) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d exp T(%0d %0d %0d) B(%0d %0d %0d) d%0b got T(%0d %0d %0d) B(%0d %0d %0d) d%0b",
                     n_results, e.tx, e.ty, e.tz, e.bx, e.by, e.bz, e.degen,
                     res.tangent_x, res.tangent_y, res.tangent_z, res.bitangent_x,
                     res.bitangent_y, res.bitangent_z, res.degenerate);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 28;
    recv_idle_pct = 66;
    test_random(70);
    test_pause();
    send_idle_pct = 66;
    recv_idle_pct = 28;
    test_random(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(66);
    vtx.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("Covered %0d vertices, %0d triangles checked (%0d degenerate, %0d saturating).",
             n_vertices, n_results, n_degen, n_sat);
    if (n_errors == 0 && basis_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_errors, basis_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
